// ===== src/nbsl_pkg.sv =====
// shared types and constants for the nine-bit serial link engine
package nbsl_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TX    = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WAIT = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;
    localparam logic [1:0] MODE_TX   = 2'd3;

    localparam logic [3:0] INDEX_NONE   = 4'd15;
    localparam logic [3:0] INDEX_CMD    = 4'd8;
    localparam logic [3:0] INDEX_STOP   = 4'd9;
    localparam logic [3:0] IDLE_GAP_RST = 4'd10;

    typedef struct packed {
        logic [1:0] op;
        logic       line_bit;
        logic       tx_ready;
        logic [7:0] tx_data;
        logic       tx_is_command;
        logic       tx_last;
    } nbsl_in_t;

    typedef struct packed {
        logic       rx_accept;
        logic       drive_valid;
        logic       line_drive;
        logic       byte_valid;
        logic [7:0] rx_data;
        logic       rx_command;
        logic       framing_error;
        logic       collision;
        logic       tx_confirmed;
        logic [3:0] idle_wait_bits;
        logic [1:0] bus_status;
    } nbsl_out_t;

endpackage

// ===== src/nine_bit_serial_link_collision.sv =====
// top level of the nine-bit serial link bit engine with collision detect
// Each event (start edge, receive sample tick, transmit tick) is taken into an
// input register, handled combinationally by the core against the bus state, and
// its one result is placed in an output register. One event is accepted every
// cycle as long as the result side keeps taking transfers; between input
// transfer and result valid lie the input register and the result register.
// The idle gap register (reset 10) is written through cfg_we / cfg_wdata at any
// edge and takes effect on the next event handled.
module nine_bit_serial_link_collision (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  nbsl_pkg::nbsl_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nbsl_pkg::nbsl_out_t m_data
);
    import nbsl_pkg::*;

    logic      ev_valid;
    logic      res_ready;
    logic      step;
    nbsl_in_t  ev;
    nbsl_out_t res;

    assign step = ev_valid && res_ready;

    nbsl_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (ev_valid),
        .q_take  (step),
        .q_data  (ev)
    );

    nbsl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .ev        (ev),
        .res       (res)
    );

    nbsl_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (ev_valid),
        .d_ready (res_ready),
        .d_data  (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // input side only stalls when both registers are full and the sink stalls
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while result register free");

    a_ferr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.framing_error) |->
            (m_data.bus_status == MODE_IDLE && !m_data.byte_valid && !m_data.collision))
        else $error("framing error without idle bus");

    a_coll_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.collision) |->
            (!m_data.tx_confirmed && !m_data.byte_valid && m_data.bus_status == MODE_WAIT))
        else $error("collision result inconsistent");

    a_rx_data_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.byte_valid) |-> (m_data.rx_data == 8'd0 && !m_data.rx_command))
        else $error("received data shown without a byte");
endmodule

// ===== src/nbsl_in_reg.sv =====
// input register stage: holds one event until the core takes it
module nbsl_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nbsl_pkg::nbsl_in_t s_data,
    output logic              q_valid,
    input  logic              q_take,
    output nbsl_pkg::nbsl_in_t q_data
);
    import nbsl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    nbsl_in_t data_reg;

    // refill in the same cycle the held event moves on
    assign s_ready    = !valid_reg || q_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;
endmodule

// ===== src/nbsl_core.sv =====
// bus state, receive and transmit bit counters, and the per-event step logic
module nbsl_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               step,
    input  nbsl_pkg::nbsl_in_t ev,
    output nbsl_pkg::nbsl_out_t res
);
    import nbsl_pkg::*;

    logic [3:0] gap_reg;
    logic [1:0] mode_reg,    mode_next;
    logic [3:0] rx_idx_reg,  rx_idx_next;
    logic [7:0] rx_shift_reg, rx_shift_next;
    logic       rx_cmd_reg,  rx_cmd_next;
    logic [3:0] tx_idx_reg,  tx_idx_next;
    logic [7:0] tx_hold_reg, tx_hold_next;
    logic       tx_cmd_reg,  tx_cmd_next;
    logic       tx_last_reg, tx_last_next;

    logic [3:0] rx_idx;
    logic [7:0] rx_base;

    always_comb begin
        mode_next     = mode_reg;
        rx_idx_next   = rx_idx_reg;
        rx_shift_next = rx_shift_reg;
        rx_cmd_next   = rx_cmd_reg;
        tx_idx_next   = tx_idx_reg;
        tx_hold_next  = tx_hold_reg;
        tx_cmd_next   = tx_cmd_reg;
        tx_last_next  = tx_last_reg;
        res           = '0;

        // first tick after a start edge is data bit 0
        rx_idx  = (rx_idx_reg == INDEX_NONE) ? 4'd0 : rx_idx_reg + 4'd1;
        rx_base = (rx_idx == 4'd0) ? 8'd0 : rx_shift_reg;

        case (ev.op)
            OP_START: begin
                if (rx_idx_reg == INDEX_NONE) begin
                    res.rx_accept = 1'b1;
                    if (mode_reg == MODE_IDLE || mode_reg == MODE_WAIT) begin
                        mode_next = MODE_RX;
                    end
                end
            end
            OP_RX: begin
                if (rx_idx <= 4'd7) begin
                    rx_shift_next = rx_base | (8'(ev.line_bit) << rx_idx[2:0]);
                    if (rx_idx == 4'd0) begin
                        rx_cmd_next = 1'b0;
                    end
                    rx_idx_next = rx_idx;
                end else if (rx_idx == INDEX_CMD) begin
                    rx_cmd_next = ev.line_bit;
                    rx_idx_next = rx_idx;
                end else begin
                    // stop bit, also any stray index
                    rx_idx_next = INDEX_NONE;
                    if (!ev.line_bit) begin
                        res.framing_error = 1'b1;
                        mode_next         = MODE_IDLE;
                    end else begin
                        mode_next = MODE_WAIT;
                        if (mode_reg == MODE_TX && rx_shift_reg != tx_hold_reg) begin
                            res.collision      = 1'b1;
                            res.idle_wait_bits = gap_reg;
                        end else begin
                            res.byte_valid = 1'b1;
                            res.rx_data    = rx_shift_reg;
                            res.rx_command = rx_cmd_reg;
                            if (mode_reg == MODE_TX) begin
                                res.tx_confirmed = 1'b1;
                                if (tx_last_reg) begin
                                    res.idle_wait_bits = gap_reg;
                                end
                            end else begin
                                res.idle_wait_bits = gap_reg;
                            end
                        end
                    end
                end
            end
            OP_TX: begin
                if (tx_idx_reg == INDEX_NONE) begin
                    if (mode_reg == MODE_WAIT) begin
                        mode_next = MODE_IDLE;
                    end
                    if (ev.tx_ready) begin
                        tx_hold_next    = ev.tx_data;
                        tx_cmd_next     = ev.tx_is_command;
                        tx_last_next    = ev.tx_last;
                        mode_next       = MODE_TX;
                        res.drive_valid = 1'b1;
                        tx_idx_next     = 4'd0;
                    end
                end else if (tx_idx_reg <= 4'd7) begin
                    res.drive_valid = 1'b1;
                    res.line_drive  = tx_hold_reg[tx_idx_reg[2:0]];
                    tx_idx_next     = tx_idx_reg + 4'd1;
                end else if (tx_idx_reg == INDEX_CMD) begin
                    res.drive_valid = 1'b1;
                    res.line_drive  = tx_cmd_reg;
                    tx_idx_next     = INDEX_STOP;
                end else begin
                    res.drive_valid = 1'b1;
                    res.line_drive  = 1'b1;
                    tx_idx_next     = INDEX_NONE;
                end
            end
            default: begin
            end
        endcase

        res.bus_status = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg      <= IDLE_GAP_RST;
            mode_reg     <= MODE_IDLE;
            rx_idx_reg   <= INDEX_NONE;
            rx_shift_reg <= 8'd0;
            rx_cmd_reg   <= 1'b0;
            tx_idx_reg   <= INDEX_NONE;
            tx_hold_reg  <= 8'd0;
            tx_cmd_reg   <= 1'b1;
            tx_last_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                gap_reg <= cfg_wdata;
            end
            if (step) begin
                mode_reg     <= mode_next;
                rx_idx_reg   <= rx_idx_next;
                rx_shift_reg <= rx_shift_next;
                rx_cmd_reg   <= rx_cmd_next;
                tx_idx_reg   <= tx_idx_next;
                tx_hold_reg  <= tx_hold_next;
                tx_cmd_reg   <= tx_cmd_next;
                tx_last_reg  <= tx_last_next;
            end
        end
    end
endmodule

// ===== src/nbsl_out_reg.sv =====
// result register: holds one result until the sink takes the transfer
module nbsl_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                d_valid,
    output logic                d_ready,
    input  nbsl_pkg::nbsl_out_t d_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nbsl_pkg::nbsl_out_t m_data
);
    import nbsl_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    nbsl_out_t data_reg;

    assign d_ready    = !valid_reg || m_ready;
    assign valid_next = d_ready ? d_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_valid && d_ready) begin
            data_reg <= d_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the nine-bit serial link bit engine
`timescale 1ns / 100ps

module testbench;
    import nbsl_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 9;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          LONG_HOLD      = 300;
    localparam int          PHASE_ITEMS    = 206;
    localparam int          NUM_PHASES     = 5;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          TAIL_CYCLES    = 8;
    localparam int          MAX_PRINTS     = 60;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [7:0]  RX_PATTERN     = 8'hB5;

    typedef struct {
        nbsl_in_t  ev;
        bit        typed;
        nbsl_out_t want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [3:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    nbsl_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    nbsl_out_t m_data;

    // predictor copy of the link state
    logic [1:0] bus_mode_q;
    logic [3:0] rx_idx_q;
    logic [7:0] rx_shift_q;
    logic       rx_cmd_q;
    logic [3:0] tx_idx_q;
    logic [7:0] tx_byte_q;
    logic       tx_cmd_q;
    logic       tx_last_q;
    logic [3:0] gap_bits_q;

    nbsl_out_t  pending_link_results[$];
    stim_row_t  directed_rows[$];
    int         mismatches;
    int         results_seen;
    int         items_sent;
    int unsigned quiet_cycles;
    bit         tx_idling;
    bit         rx_idling;
    bit         long_hold_req;
    int         hold_left;

    nine_bit_serial_link_collision u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic reset_link_model();
        bus_mode_q = MODE_IDLE;
        rx_idx_q   = INDEX_NONE;
        rx_shift_q = '0;
        rx_cmd_q   = 1'b0;
        tx_idx_q   = INDEX_NONE;
        tx_byte_q  = '0;
        tx_cmd_q   = 1'b1;
        tx_last_q  = 1'b0;
        gap_bits_q = IDLE_GAP_RST;
    endtask

    function automatic nbsl_out_t predict_link_event(nbsl_in_t ev);
        nbsl_out_t  r;
        logic [3:0] idx;
        logic [1:0] prior;
        r = '0;
        case (ev.op)
            OP_START: begin
                if (rx_idx_q == INDEX_NONE) begin
                    r.rx_accept = 1'b1;
                    if (bus_mode_q == MODE_IDLE || bus_mode_q == MODE_WAIT)
                        bus_mode_q = MODE_RX;
                end
            end
            OP_RX: begin
                idx = (rx_idx_q == INDEX_NONE) ? 4'd0 : rx_idx_q + 4'd1;
                if (idx == 4'd0) begin
                    rx_shift_q = '0;
                    rx_cmd_q   = 1'b0;
                end
                if (idx <= 4'd7) begin
                    rx_shift_q[idx[2:0]] = rx_shift_q[idx[2:0]] | ev.line_bit;
                    rx_idx_q = idx;
                end else if (idx == INDEX_CMD) begin
                    rx_cmd_q = ev.line_bit;
                    rx_idx_q = idx;
                end else begin
                    // stop bit, also taken for any stray index
                    rx_idx_q = INDEX_NONE;
                    if (!ev.line_bit) begin
                        r.framing_error = 1'b1;
                        bus_mode_q = MODE_IDLE;
                    end else begin
                        prior = bus_mode_q;
                        bus_mode_q = MODE_WAIT;
                        if (prior == MODE_TX && rx_shift_q != tx_byte_q) begin
                            r.collision      = 1'b1;
                            r.idle_wait_bits = gap_bits_q;
                        end else begin
                            r.byte_valid = 1'b1;
                            r.rx_data    = rx_shift_q;
                            r.rx_command = rx_cmd_q;
                            if (prior == MODE_TX) begin
                                r.tx_confirmed = 1'b1;
                                if (tx_last_q)
                                    r.idle_wait_bits = gap_bits_q;
                            end else begin
                                r.idle_wait_bits = gap_bits_q;
                            end
                        end
                    end
                end
            end
            OP_TX: begin
                if (tx_idx_q == INDEX_NONE) begin
                    if (bus_mode_q == MODE_WAIT)
                        bus_mode_q = MODE_IDLE;
                    if (ev.tx_ready) begin
                        tx_byte_q     = ev.tx_data;
                        tx_cmd_q      = ev.tx_is_command;
                        tx_last_q     = ev.tx_last;
                        bus_mode_q    = MODE_TX;
                        r.drive_valid = 1'b1;
                        tx_idx_q      = 4'd0;
                    end
                end else if (tx_idx_q <= 4'd7) begin
                    r.drive_valid = 1'b1;
                    r.line_drive  = tx_byte_q[tx_idx_q[2:0]];
                    tx_idx_q      = tx_idx_q + 4'd1;
                end else if (tx_idx_q == INDEX_CMD) begin
                    r.drive_valid = 1'b1;
                    r.line_drive  = tx_cmd_q;
                    tx_idx_q      = INDEX_STOP;
                end else begin
                    r.drive_valid = 1'b1;
                    r.line_drive  = 1'b1;
                    tx_idx_q      = INDEX_NONE;
                end
            end
            default: begin
            end
        endcase
        r.bus_status = bus_mode_q;
        return r;
    endfunction

    function automatic string describe_field_diffs(nbsl_out_t got, nbsl_out_t want);
        string s;
        s = "";
        if (got.rx_accept !== want.rx_accept)           s = {s, " rx_accept"};
        if (got.drive_valid !== want.drive_valid)       s = {s, " drive_valid"};
        if (got.line_drive !== want.line_drive)         s = {s, " line_drive"};
        if (got.byte_valid !== want.byte_valid)         s = {s, " byte_valid"};
        if (got.rx_data !== want.rx_data)               s = {s, " rx_data"};
        if (got.rx_command !== want.rx_command)         s = {s, " rx_command"};
        if (got.framing_error !== want.framing_error)   s = {s, " framing_error"};
        if (got.collision !== want.collision)           s = {s, " collision"};
        if (got.tx_confirmed !== want.tx_confirmed)     s = {s, " tx_confirmed"};
        if (got.idle_wait_bits !== want.idle_wait_bits) s = {s, " idle_wait_bits"};
        if (got.bus_status !== want.bus_status)         s = {s, " bus_status"};
        return s;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic nbsl_in_t mk_ev(logic [1:0] op, logic line_bit, logic ready,
                                       logic [7:0] data, logic cmd, logic last);
        nbsl_in_t ev;
        ev.op            = op;
        ev.line_bit      = line_bit;
        ev.tx_ready      = ready;
        ev.tx_data       = data;
        ev.tx_is_command = cmd;
        ev.tx_last       = last;
        return ev;
    endfunction

    function automatic nbsl_out_t flags_only(logic accept, logic dvalid, logic ferr,
                                             logic [1:0] status);
        nbsl_out_t r;
        r               = '0;
        r.rx_accept     = accept;
        r.drive_valid   = dvalid;
        r.framing_error = ferr;
        r.bus_status    = status;
        return r;
    endfunction

    function automatic stim_row_t stim_row(nbsl_in_t ev, bit typed, nbsl_out_t want);
        stim_row_t row;
        row.ev    = ev;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic nbsl_in_t rand_ev();
        logic [31:0] r;
        nbsl_in_t    ev;
        r  = $urandom;
        ev = r[13:0];
        case ($urandom_range(0, 7))
            0: ev.tx_data = 8'hFF;
            1: ev.tx_data = 8'h00;
            default: begin
            end
        endcase
        return ev;
    endfunction

    // offer one event, wait for its transfer, then log what it should produce
    task automatic send_item(nbsl_in_t ev, bit typed = 1'b0, nbsl_out_t want = '0);
        nbsl_out_t predicted;
        if (tx_idling && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_link_event(ev);
        pending_link_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_link_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_idle_gap(logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        gap_bits_q = value;
    endtask

    task automatic run_episode();
        nbsl_in_t   ev;
        logic [7:0] data;
        logic       cmd;
        logic       stop;
        int         kind;
        int         n;
        int         flip;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // noise: anything goes, unused op included
            n = $urandom_range(1, 6);
            repeat (n) send_item(rand_ev());
            return;
        end
        // finish any character in progress so the sequence starts clean
        while (tx_idx_q != INDEX_NONE) begin
            ev = rand_ev();
            ev.op = OP_TX;
            send_item(ev);
        end
        while (rx_idx_q != INDEX_NONE) begin
            ev = rand_ev();
            ev.op = OP_RX;
            ev.line_bit = 1'b1;
            send_item(ev);
        end
        if (kind < 45) begin
            data = 8'($urandom);
            cmd  = 1'($urandom);
            stop = ($urandom_range(0, 7) != 0);
            ev = rand_ev();
            ev.op = OP_START;
            send_item(ev);
            if ($urandom_range(0, 3) == 0)
                send_item(ev);
            for (int k = 0; k < 10; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    ev = rand_ev();
                    ev.op = OP_START;
                    send_item(ev);
                end
                // transmitter may grab the bus mid-character
                if ($urandom_range(0, 19) == 0) begin
                    ev = rand_ev();
                    ev.op = OP_TX;
                    ev.tx_ready = 1'b1;
                    send_item(ev);
                end
                ev = rand_ev();
                ev.op = OP_RX;
                ev.line_bit = (k < 8) ? data[k] : (k == 8) ? cmd : stop;
                send_item(ev);
            end
        end else if (kind < 90) begin
            ev = rand_ev();
            ev.op = OP_TX;
            ev.tx_ready = 1'b1;
            send_item(ev);
            data = ev.tx_data;
            cmd  = ev.tx_is_command;
            stop = ($urandom_range(0, 9) != 0);
            flip = $urandom_range(0, 99);
            if (flip < 15)
                data[3'($urandom_range(0, 7))] ^= 1'b1;
            else if (flip < 30)
                cmd = ~cmd;
            ev = rand_ev();
            ev.op = OP_START;
            send_item(ev);
            for (int k = 0; k < 10; k++) begin
                ev = rand_ev();
                ev.op = OP_TX;
                send_item(ev);
                ev = rand_ev();
                ev.op = OP_RX;
                ev.line_bit = (k < 8) ? data[k] : (k == 8) ? cmd : stop;
                send_item(ev);
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                ev = rand_ev();
                ev.op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_TX;
                ev.tx_ready = 1'b0;
                send_item(ev);
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (rx_idling && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        nbsl_out_t want;
        string     diffs;
        if (aresetn && m_valid && m_ready) begin
            if (pending_link_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", m_data));
            end else begin
                want  = pending_link_results.pop_front();
                diffs = describe_field_diffs(m_data, want);
                if (diffs != "")
                    report_mismatch($sformatf("result %0d wrong:%s got %h want %h",
                                              results_seen, diffs, m_data, want));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [3:0] gap;
        int         phase_end;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        items_sent    = 0;
        quiet_cycles  = 0;
        hold_left     = 0;
        long_hold_req = 1'b0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        reset_link_model();

        directed_rows.push_back(stim_row(mk_ev(OP_UNUSED, 1, 1, 8'hFF, 1, 1), 1,
                                         flags_only(0, 0, 0, MODE_IDLE)));
        directed_rows.push_back(stim_row(mk_ev(OP_TX, 0, 0, 8'h00, 0, 0), 1,
                                         flags_only(0, 0, 0, MODE_IDLE)));
        directed_rows.push_back(stim_row(mk_ev(OP_START, 1, 1, 8'h5A, 1, 0), 1,
                                         flags_only(1, 0, 0, MODE_RX)));
        // repeated edge before any sample tick is still taken
        directed_rows.push_back(stim_row(mk_ev(OP_START, 0, 0, 8'hA5, 0, 1), 1,
                                         flags_only(1, 0, 0, MODE_RX)));
        directed_rows.push_back(stim_row(mk_ev(OP_RX, RX_PATTERN[0], 0, 8'h00, 0, 0), 1,
                                         flags_only(0, 0, 0, MODE_RX)));
        directed_rows.push_back(stim_row(mk_ev(OP_START, 1, 0, 8'h00, 0, 0), 1,
                                         flags_only(0, 0, 0, MODE_RX)));
        for (int i = 1; i < 8; i++)
            directed_rows.push_back(stim_row(mk_ev(OP_RX, RX_PATTERN[i], i[0], 8'h3C,
                                                   0, 1), 0, '0));
        directed_rows.push_back(stim_row(mk_ev(OP_RX, 1, 0, 8'h00, 1, 0), 0, '0));
        // low stop bit
        directed_rows.push_back(stim_row(mk_ev(OP_RX, 0, 1, 8'hFF, 1, 1), 1,
                                         flags_only(0, 0, 1, MODE_IDLE)));
        directed_rows.push_back(stim_row(mk_ev(OP_START, 0, 0, 8'h00, 0, 0), 1,
                                         flags_only(1, 0, 0, MODE_RX)));
        // transmitter takes the bus while a character is being received
        directed_rows.push_back(stim_row(mk_ev(OP_TX, 0, 1, 8'hFF, 1, 1), 1,
                                         flags_only(0, 1, 0, MODE_TX)));
        directed_rows.push_back(stim_row(mk_ev(OP_START, 1, 1, 8'h00, 0, 0), 1,
                                         flags_only(1, 0, 0, MODE_TX)));
        directed_rows.push_back(stim_row(mk_ev(OP_TX, 1, 0, 8'h00, 0, 0), 0, '0));
        directed_rows.push_back(stim_row(mk_ev(OP_RX, 1, 1, 8'hFF, 1, 1), 0, '0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender waits for every result before touching the register
            drain_results();
            case (p)
                0: gap = 4'd15;
                1: gap = 4'd1;
                2: gap = 4'd0;
                3: gap = 4'($urandom_range(2, 14));
                default: gap = IDLE_GAP_RST;
            endcase
            write_idle_gap(gap);
            tx_idling = (p != NUM_PHASES - 1);
            rx_idling = (p != NUM_PHASES - 1);
            if (p == 1)
                long_hold_req = 1'b1;
            phase_end = directed_rows.size() + (p + 1) * PHASE_ITEMS;
            while (items_sent < phase_end)
                run_episode();
        end

        s_valid <= 1'b0;
        while (pending_link_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/nbsl_pkg.sv
src/nbsl_in_reg.sv
src/nbsl_core.sv
src/nbsl_out_reg.sv
src/nine_bit_serial_link_collision.sv
tb/testbench.sv
